// ----- rtl/dq_pkg.sv -----
package dq_pkg;

  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// ----- rtl/dq_if.sv -----
interface dq_req_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface dq_rsp_if;
  import dq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] word;
  logic [STATUS_W-1:0]      status;
  logic                     last;

  modport source (output valid, output word, output status, output last, input ready);
  modport sink   (input valid, input word, input status, input last, output ready);
endinterface

// ----- rtl/double_ended_queue.sv -----
// Channel | Role     | Beat carries
// --------+----------+---------------------------------------------
// req     | sink     | op (3b), value (32b signed)
// rsp     | source   | word (32b signed), status (2b), last (1b)
//
// Push, pop and clear each answer with a single rsp beat; ignored codes give
// none. A dump sends the stored entries front to back, one per rsp beat, through
// the single read port of the ring memory; its registered read data stands directly as the rsp word.
// Synchronous active-high reset empties the queue; memory contents are kept.
// A stalled rsp holds req off: a new beat is taken only when the output
// register is empty or being drained in the same cycle.
module double_ended_queue #(
  parameter int DEPTH = 32
) (
  input  logic    clk,
  input  logic    rst,
  dq_req_if.sink  req,
  dq_rsp_if.source rsp
);
  import dq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t                   state, state_next;
  logic [AW-1:0]            front, front_next;
  logic [CW-1:0]            count, count_next;
  logic [AW-1:0]            dump_idx, dump_idx_next;
  logic                     out_valid, out_valid_next;
  logic                     sel_mem, sel_mem_next;
  logic signed [WORD_W-1:0] word_reg, word_reg_next;
  status_t                  status_reg, status_reg_next;
  logic                     last_reg, last_reg_next;

  logic [WORD_W-1:0]        mem [DEPTH];
  logic [WORD_W-1:0]        rd_data;
  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [WORD_W-1:0]        wr_data;

  logic                     accept, out_free, full, empty, dump_last;
  logic [AW-1:0]            front_dec;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign dump_last = ((CW'(dump_idx) + CW'(1)) == count);

  assign rsp.valid  = out_valid;
  assign rsp.word   = sel_mem ? $signed(rd_data) : word_reg;
  assign rsp.status = status_reg;
  assign rsp.last   = last_reg;

  always_comb begin
    state_next      = state;
    front_next      = front;
    count_next      = count;
    dump_idx_next   = dump_idx;
    out_valid_next  = out_valid && !rsp.ready;
    sel_mem_next    = sel_mem;
    word_reg_next   = word_reg;
    status_reg_next = status_reg;
    last_reg_next   = last_reg;
    wr_en           = 1'b0;
    wr_addr         = front_dec;
    wr_data         = req.value;
    rd_en           = 1'b0;
    rd_addr         = front;

    if (accept) begin
      case (op_t'(req.op))
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          out_valid_next = 1'b1;
          sel_mem_next   = 1'b0;
          word_reg_next  = req.value;
          last_reg_next  = 1'b1;
          if (full) begin
            status_reg_next = ST_FULL;
          end else begin
            status_reg_next = ST_OK;
            wr_en           = 1'b1;
            count_next      = count + CW'(1);
            if (op_t'(req.op) == OP_PUSH_FRONT) begin
              wr_addr    = front_dec;
              front_next = front_dec;
            end else begin
              wr_addr = ring_add(front, count);
            end
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          out_valid_next = 1'b1;
          last_reg_next  = 1'b1;
          if (empty) begin
            sel_mem_next    = 1'b0;
            word_reg_next   = '0;
            status_reg_next = ST_EMPTY;
          end else begin
            rd_en           = 1'b1;
            sel_mem_next    = 1'b1;
            status_reg_next = ST_OK;
            count_next      = count - CW'(1);
            if (op_t'(req.op) == OP_POP_FRONT) begin
              rd_addr    = front;
              front_next = ring_add(front, CW'(1));
            end else begin
              rd_addr = ring_add(front, count - CW'(1));
            end
          end
        end
        OP_DUMP: begin
          out_valid_next = 1'b1;
          if (empty) begin
            sel_mem_next    = 1'b0;
            word_reg_next   = '0;
            status_reg_next = ST_EMPTY;
            last_reg_next   = 1'b1;
          end else begin
            rd_en           = 1'b1;
            rd_addr         = front;
            sel_mem_next    = 1'b1;
            status_reg_next = ST_OK;
            last_reg_next   = (count == CW'(1));
            dump_idx_next   = AW'(1);
            if (count != CW'(1)) begin
              state_next = S_DUMP;
            end
          end
        end
        OP_CLEAR: begin
          count_next      = '0;
          front_next      = '0;
          out_valid_next  = 1'b1;
          sel_mem_next    = 1'b0;
          word_reg_next   = '0;
          status_reg_next = ST_OK;
          last_reg_next   = 1'b1;
        end
        default: begin
          // drop unused codes without a result
        end
      endcase
    end else if (state == S_DUMP && out_free) begin
      // advance one entry per beat; the read lands in the output slot
      rd_en           = 1'b1;
      rd_addr         = ring_add(front, CW'(dump_idx));
      out_valid_next  = 1'b1;
      sel_mem_next    = 1'b1;
      status_reg_next = ST_OK;
      last_reg_next   = dump_last;
      dump_idx_next   = dump_idx + AW'(1);
      if (dump_last) begin
        state_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    dump_idx   <= dump_idx_next;
    sel_mem    <= sel_mem_next;
    word_reg   <= word_reg_next;
    status_reg <= status_reg_next;
    last_reg   <= last_reg_next;
  end

endmodule

// ----- rtl/dq_checker.sv -----
module dq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic [dq_pkg::OP_W-1:0]          req_op,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic signed [dq_pkg::WORD_W-1:0] rsp_word,
  input logic [dq_pkg::STATUS_W-1:0]      rsp_status,
  input logic                             rsp_last
);
  import dq_pkg::*;

  // hold a stalled rsp beat
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word)
      && $stable(rsp_status) && $stable(rsp_last))
    else $error("rsp beat changed while stalled");

  assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> !rsp_valid || rsp_ready)
    else $error("req taken while a result is stalled");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_EMPTY) |-> rsp_last)
    else $error("full or empty result not marked last");

  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_op == OP_CLEAR |=>
      rsp_valid && rsp_last && rsp_status == ST_OK && rsp_word == '0)
    else $error("clear did not answer with an ok beat");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_op     (req.op),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_word   (rsp.word),
  .rsp_status (rsp.status),
  .rsp_last   (rsp.last)
);
